// ----- rtl/coupon_collector_expectation_defines.svh -----
// Assertion macros shared by the coupon collector expectation RTL.
`ifndef COUPON_COLLECTOR_EXPECTATION_DEFINES_SVH
`define COUPON_COLLECTOR_EXPECTATION_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication check, disabled while reset is asserted.
`define CCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication check, disabled while reset is asserted.
`define CCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define CCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/cce_pkg.sv -----
// Package with widths, limits and beat/request types of the coupon collector block.
`timescale 1ns / 1ps
`default_nettype none

package cce_pkg;

  // Field widths of the input and result beats.
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned WHOLE_W = 8;
  localparam int unsigned NUM_W   = 48;
  localparam int unsigned DEN_W   = 49;

  // Internal datapath width and the step counter width of the shared units.
  localparam int unsigned DATA_W = 64;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  // Largest count that gives a result, and the first harmonic term added.
  localparam int unsigned MAX_N      = 33;
  localparam int unsigned FIRST_TERM = 2;

  typedef logic [DATA_W-1:0] data_t;

  typedef struct packed {
    logic [COUNT_W-1:0] coupon_count;
  } in_item_t;

  typedef struct packed {
    logic [WHOLE_W-1:0] whole_part;
    logic [NUM_W-1:0]   frac_numerator;
    logic [DEN_W-1:0]   frac_denominator;
    logic               is_whole;
    logic               overflow;
  } out_item_t;

  // Request and response of the gcd unit.
  typedef struct packed {
    logic  start;
    data_t a;
    data_t b;
  } gcd_req_t;

  typedef struct packed {
    logic  done;
    data_t result;
  } gcd_rsp_t;

  // Request and response of the divider.
  typedef struct packed {
    logic  start;
    data_t dividend;
    data_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    data_t quotient;
    data_t remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/cce_intf.sv -----
// Valid/ready channel interfaces for the input and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface cce_in_if;
  import cce_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cce_out_if;
  import cce_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/cce_gcd.sv -----
// Binary (shift and subtract) greatest common divisor unit, one step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module cce_gcd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cce_pkg::gcd_req_t req_i,
  output cce_pkg::gcd_rsp_t rsp_o
);
  import cce_pkg::*;

  typedef enum logic [2:0] {
    G_IDLE  = 3'b001,
    G_STRIP = 3'b010,
    G_RUN   = 3'b100
  } gcd_state_e;

  gcd_state_e state_q, state_d;
  logic       done_q, done_d;
  data_t      a_q, a_d, b_q, b_d, res_q, res_d;
  logic [CNT_W-1:0] k_q, k_d;

  // Sequencer: a zero operand returns the other; else strip common factors of two, then halve even values and subtract.
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    res_d   = res_q;
    unique case (state_q)
      G_IDLE: begin
        if (req_i.start) begin
          a_d = req_i.a;
          b_d = req_i.b;
          k_d = '0;
          if (req_i.a == '0) begin
            res_d  = req_i.b;
            done_d = 1'b1;
          end else if (req_i.b == '0) begin
            res_d  = req_i.a;
            done_d = 1'b1;
          end else begin
            state_d = G_STRIP;
          end
        end
      end
      G_STRIP: begin
        if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + CNT_W'(1);
        end else begin
          state_d = G_RUN;
        end
      end
      G_RUN: begin
        if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q == b_q) begin
          res_d   = a_q << k_q;
          done_d  = 1'b1;
          state_d = G_IDLE;
        end else if (a_q > b_q) begin
          a_d = a_q - b_q;
        end else begin
          b_d = b_q - a_q;
        end
      end
      default: begin
        state_d = G_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule

`default_nettype wire

// ----- rtl/cce_divider.sv -----
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
`timescale 1ns / 1ps
`default_nettype none
`include "coupon_collector_expectation_defines.svh"

module cce_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cce_pkg::div_req_t req_i,
  output cce_pkg::div_rsp_t rsp_o
);
  import cce_pkg::*;

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  data_t            quo_q, rem_q, div_q;
  logic [DATA_W:0]  trial, diff;
  logic             fits;

  // One trial subtraction per cycle.
  assign trial = {rem_q, quo_q[DATA_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  // Control: busy until all DATA_W quotient bits are formed, then a one-cycle done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DATA_W-2:0], fits};
      rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  // A start always leaves the unit busy in the next cycle.
  `CCE_ASSERT_NXT(a_div_busy_after_start, clk_i, rst_ni, req_i.start, busy_q)
  // The done pulse lasts a single cycle.
  `CCE_ASSERT_NXT(a_div_done_pulse, clk_i, rst_ni, done_q, !done_q)
  // A finished division leaves a remainder below a nonzero divisor.
  `CCE_ASSERT_IMP(a_div_rem_range, clk_i, rst_ni, done_q && (div_q != '0), rem_q < div_q)

endmodule

`default_nettype wire

// ----- rtl/coupon_collector_expectation.sv -----
// Top level: sequencer that builds n*H(n) as a reduced mixed fraction.
//
//   Channel | Dir | Beat contents                                            | Handshake
//   in_i    | in  | coupon_count                                             | valid/ready
//   out_o   | out | whole_part, frac_numerator, frac_denominator, is_whole,  | valid/ready
//           |     | overflow                                                 |
//
// Each harmonic step runs the multiply states S_MUL_NUM and S_MUL_DEN, a binary gcd and,
// when the gcd exceeds one, a division of the numerator and then of the denominator. The
// final scaling, reduction and split add one gcd and up to three divisions.
// Counts above the limit skip to S_DONE; the overflow beat loads when the output register is free.
// Reset is asynchronous and active low; there is no clearing pass.
// A new count is taken while a finished result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "coupon_collector_expectation_defines.svh"

module coupon_collector_expectation (
  input  logic      clk_i,
  input  logic      rst_ni,
  cce_in_if.sink    in_i,
  cce_out_if.source out_o
);
  import cce_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE       = 14'b00000000000001,
    S_MUL_NUM    = 14'b00000000000010,
    S_MUL_DEN    = 14'b00000000000100,
    S_GCD_GO     = 14'b00000000001000,
    S_GCD_WAIT   = 14'b00000000010000,
    S_DIVN_GO    = 14'b00000000100000,
    S_DIVN_WAIT  = 14'b00000001000000,
    S_DIVD_GO    = 14'b00000010000000,
    S_DIVD_WAIT  = 14'b00000100000000,
    S_NEXT       = 14'b00001000000000,
    S_SCALE      = 14'b00010000000000,
    S_SPLIT_GO   = 14'b00100000000000,
    S_SPLIT_WAIT = 14'b01000000000000,
    S_DONE       = 14'b10000000000000
  } seq_state_e;

  seq_state_e state_q, state_d;
  logic       ovf_q, ovf_d, final_q, final_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  logic [COUNT_W-1:0] n_q, n_d, i_q, i_d;
  data_t              num_q, num_d, den_q, den_d, g_q, g_d;
  logic [WHOLE_W-1:0] whole_q, whole_d;

  logic in_ready, in_fire, out_fire, out_load;

  data_t                     mul_a, mul_add, mul_res;
  logic [COUNT_W-1:0]        mul_b;
  logic [DATA_W+COUNT_W-1:0] mul_prod;

  gcd_req_t gcd_req;
  gcd_rsp_t gcd_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_ready = (state_q == S_IDLE);
  assign in_fire  = in_i.valid && in_ready;
  assign out_fire = out_valid_q && out_o.ready;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  // Small multiplier: operand times a 6-bit count, plus an addend.
  always_comb begin
    mul_a   = num_q;
    mul_b   = i_q;
    mul_add = den_q;
    if (state_q == S_MUL_DEN) begin
      mul_a   = den_q;
      mul_add = '0;
    end else if (state_q == S_SCALE) begin
      mul_b   = n_q;
      mul_add = '0;
    end
  end

  assign mul_prod = {{COUNT_W{1'b0}}, mul_a} * {{DATA_W{1'b0}}, mul_b};
  assign mul_res  = mul_prod[DATA_W-1:0] + mul_add;

  // Requests to the shared gcd unit and divider.
  always_comb begin
    gcd_req.start = (state_q == S_GCD_GO);
    gcd_req.a     = num_q;
    gcd_req.b     = den_q;

    div_req.start    = (state_q == S_DIVN_GO) || (state_q == S_DIVD_GO) ||
                       (state_q == S_SPLIT_GO);
    div_req.dividend = num_q;
    div_req.divisor  = g_q;
    if (state_q == S_DIVD_GO) begin
      div_req.dividend = den_q;
    end else if (state_q == S_SPLIT_GO) begin
      div_req.divisor = den_q;
    end
  end

  cce_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gcd_req),
    .rsp_o  (gcd_rsp)
  );

  cce_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer over the harmonic steps, the scaling and the final split.
  always_comb begin
    state_d = state_q;
    ovf_d   = ovf_q;
    final_d = final_q;
    n_d     = n_q;
    i_d     = i_q;
    num_d   = num_q;
    den_d   = den_q;
    g_d     = g_q;
    whole_d = whole_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          n_d     = in_i.payload.coupon_count;
          i_d     = COUNT_W'(FIRST_TERM);
          num_d   = DATA_W'(1);
          den_d   = DATA_W'(1);
          final_d = 1'b0;
          if (in_i.payload.coupon_count > COUNT_W'(MAX_N)) begin
            ovf_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            ovf_d = 1'b0;
            if (in_i.payload.coupon_count < COUNT_W'(FIRST_TERM)) begin
              state_d = S_SCALE;
            end else begin
              state_d = S_MUL_NUM;
            end
          end
        end
      end
      S_MUL_NUM: begin
        num_d   = mul_res;
        state_d = S_MUL_DEN;
      end
      S_MUL_DEN: begin
        den_d   = mul_res;
        state_d = S_GCD_GO;
      end
      S_GCD_GO: begin
        state_d = S_GCD_WAIT;
      end
      S_GCD_WAIT: begin
        if (gcd_rsp.done) begin
          g_d = gcd_rsp.result;
          // A divisor of one (or zero) leaves the fraction as it is.
          if (gcd_rsp.result <= DATA_W'(1)) begin
            state_d = S_NEXT;
          end else begin
            state_d = S_DIVN_GO;
          end
        end
      end
      S_DIVN_GO: begin
        state_d = S_DIVN_WAIT;
      end
      S_DIVN_WAIT: begin
        if (div_rsp.done) begin
          num_d   = div_rsp.quotient;
          state_d = S_DIVD_GO;
        end
      end
      S_DIVD_GO: begin
        state_d = S_DIVD_WAIT;
      end
      S_DIVD_WAIT: begin
        if (div_rsp.done) begin
          den_d   = div_rsp.quotient;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (final_q) begin
          state_d = S_SPLIT_GO;
        end else if (i_q == n_q) begin
          state_d = S_SCALE;
        end else begin
          i_d     = i_q + COUNT_W'(1);
          state_d = S_MUL_NUM;
        end
      end
      S_SCALE: begin
        num_d   = mul_res;
        final_d = 1'b1;
        state_d = S_GCD_GO;
      end
      S_SPLIT_GO: begin
        state_d = S_SPLIT_WAIT;
      end
      S_SPLIT_WAIT: begin
        if (div_rsp.done) begin
          whole_d = div_rsp.quotient[WHOLE_W-1:0];
          num_d   = div_rsp.remainder;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: filled from the finished fraction or the overflow flag.
  always_comb begin
    out_valid_d = out_valid_q && !out_fire;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      if (ovf_q) begin
        out_d          = '0;
        out_d.overflow = 1'b1;
      end else begin
        out_d.whole_part       = whole_q;
        out_d.frac_numerator   = num_q[NUM_W-1:0];
        out_d.frac_denominator = den_q[DEN_W-1:0];
        out_d.is_whole         = (num_q == '0);
        out_d.overflow         = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
      final_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ovf_q       <= ovf_d;
      final_q     <= final_d;
    end
  end

  // Fraction, counters and result beat.
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    i_q     <= i_d;
    num_q   <= num_d;
    den_q   <= den_d;
    g_q     <= g_d;
    whole_q <= whole_d;
    out_q   <= out_d;
  end

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // An accepted count always leaves the sequencer busy in the next cycle.
  `CCE_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_ready)
  // An overflow beat carries no fraction.
  `CCE_ASSERT_IMP(a_ovf_zero, clk_i, rst_ni,
                  out_valid_q && out_q.overflow,
                  (out_q.whole_part == '0) && (out_q.frac_denominator == '0) &&
                  !out_q.is_whole)
  // A regular beat has a nonzero denominator and a whole flag matching the numerator.
  `CCE_ASSERT_IMP(a_whole_flag, clk_i, rst_ni,
                  out_valid_q && !out_q.overflow,
                  (out_q.frac_denominator != '0) &&
                  (out_q.is_whole == (out_q.frac_numerator == '0)))

endmodule

`default_nettype wire
